### hw/rtl/ring_buffer_linear_resampler_unit_defines.svh
// Assertion helpers for the resampler RTL.
// Both expect clk and rst_n in the scope where they are used.
`ifndef RING_BUFFER_LINEAR_RESAMPLER_UNIT_DEFINES_SVH
`define RING_BUFFER_LINEAR_RESAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication
`define RBLR_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RBLR_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rblr_pkg.sv
`default_nettype none

package rblr_pkg;

  // Ring geometry and fill rules
  localparam int RING_DEPTH      = 512;
  localparam int RING_AW         = $clog2(RING_DEPTH);
  localparam int PREFILL_SAMPLES = 64;
  localparam int WRITE_GUARD     = 8;

  // Command codes carried in tuser
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_REQUEST = 3'd0;
  localparam cmd_t CMD_BEGIN   = 3'd1;
  localparam cmd_t CMD_WRITE   = 3'd2;
  localparam cmd_t CMD_END     = 3'd3;
  localparam cmd_t CMD_TICK    = 3'd4;

  // Voice states as reported on voice_phase
  typedef logic [2:0] vstate_t;
  localparam vstate_t VS_IDLE      = 3'd0;
  localparam vstate_t VS_REQUESTED = 3'd1;
  localparam vstate_t VS_RENDERING = 3'd2;
  localparam vstate_t VS_READY     = 3'd3;
  localparam vstate_t VS_PLAYING   = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PHASE_STEP  = 2'd0;
  localparam cfg_idx_t CFG_MAX_ACTIVE  = 2'd1;
  localparam cfg_idx_t CFG_MAX_STALLED = 2'd2;

  // Reset values and fixed constants
  localparam logic [16:0] PHASE_STEP_RST  = 17'd30105;
  localparam logic [23:0] MAX_ACTIVE_RST  = 24'd2880000;
  localparam logic [23:0] MAX_STALLED_RST = 24'd240000;
  localparam logic [7:0]  SILENCE         = 8'd128;

  // Saturating 24-bit increment
  function automatic logic [23:0] sat_inc24(input logic [23:0] v);
    return (&v) ? v : v + 24'd1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ring_buffer_linear_resampler_unit.sv
// Streamed-voice resampler: commands arrive on the in_ channel (cmd in tuser), one
// status/audio item leaves on the out_ channel per command. One command is in work
// at a time and in_tready is low while it runs. Request, write, render end and
// unknown commands go straight to the result state; an output tick may run two
// reads through the single read port of the sample ring and two passes through one
// shared 17x17 multiplier (interpolation, then gain). Render begin clears the ring
// to silence with one write per cycle, one for each of the RING_DEPTH entries.
// A result waiting on out_tready holds the block in its final state.
`default_nettype none

`include "ring_buffer_linear_resampler_unit_defines.svh"

module ring_buffer_linear_resampler_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata fields, low bit up: write_position[23:0], write_sample[31:24],
  // rendered_count[55:32], out_level[63:56], voice_enabled[64], zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [71:0]           in_tdata,
  // in_tuser fields: cmd[2:0]
  input  wire rblr_pkg::cmd_t        in_tuser,
  // out_tdata fields, low bit up: audio_out[15:0], accepted[16],
  // voice_phase[19:17], was_cancelled[20], zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,
  input  wire logic                  cfg_we,
  input  wire rblr_pkg::cfg_idx_t    cfg_addr,
  input  wire logic [23:0]           cfg_wdata
);
  import rblr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_WD, S_CHK, S_RDA, S_RDB, S_GAIN, S_FIN, S_DONE
  } seq_t;

  seq_t seq_r, seq_nxt;

  // Configuration
  logic [16:0] phase_step_r, phase_step_nxt;
  logic [23:0] max_active_r, max_active_nxt;
  logic [23:0] max_stalled_r, max_stalled_nxt;

  // Voice state
  logic [31:0] read_phase_r, read_phase_nxt;
  logic [23:0] produced_r, produced_nxt;
  logic [23:0] final_r, final_nxt;
  vstate_t     vstate_r, vstate_nxt;
  logic        cancel_r, cancel_nxt;
  logic [7:0]  gain_r, gain_nxt;
  logic [23:0] active_r, active_nxt;
  logic [23:0] stalled_r, stalled_nxt;
  vstate_t     seen_state_r, seen_state_nxt;
  logic [31:0] seen_phase_r, seen_phase_nxt;
  logic [23:0] seen_prod_r, seen_prod_nxt;

  // Sequencer working registers
  logic [RING_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [RING_AW-1:0] nxt_addr_r, nxt_addr_nxt;
  logic [7:0]         a_r, a_nxt;
  logic [24:0]        prod_r, prod_nxt;
  logic [15:0]        res_audio_r, res_audio_nxt;
  logic               res_acc_r, res_acc_nxt;
  cmd_t               cmd_r, cmd_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_audio_r, out_audio_nxt;
  logic        out_acc_r, out_acc_nxt;
  vstate_t     out_phase_r, out_phase_nxt;
  logic        out_cancel_r, out_cancel_nxt;

  // Ring memory
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [7:0]         rd_data_r;
  logic               mem_we;
  logic [RING_AW-1:0] mem_waddr;
  logic [7:0]         mem_wdata;
  logic [RING_AW-1:0] rd_addr;

  // Shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  // Input fields and derived values
  logic        in_fire;
  logic [23:0] in_pos, in_cnt;
  logic [7:0]  in_smp, in_lvl;
  logic        in_en;
  logic [15:0] rp_idx;
  logic [16:0] idx_inc;
  logic [16:0] wr_limit;
  logic [24:0] pos_inc;
  logic        voice_moved;
  vstate_t     st_eff;
  logic [8:0]  diff;
  logic [9:0]  interp;

  assign in_pos  = in_tdata[23:0];
  assign in_smp  = in_tdata[31:24];
  assign in_cnt  = in_tdata[55:32];
  assign in_lvl  = in_tdata[63:56];
  assign in_en   = in_tdata[64];

  assign in_tready = (seq_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cancel_r, out_phase_r, out_acc_r, out_audio_r};

  // Address math on the integer part of the phase
  assign rp_idx   = read_phase_r[31:16];
  assign idx_inc  = {1'b0, rp_idx} + 17'd1;
  assign wr_limit = {1'b0, rp_idx} + 17'(RING_DEPTH - WRITE_GUARD);
  assign pos_inc  = {1'b0, in_pos} + 25'd1;

  // Progress since the last tick, for the stall watchdog
  assign voice_moved = (vstate_r != seen_state_r) || (read_phase_r != seen_phase_r) ||
                       (produced_r != seen_prod_r);

  // A ready voice starts playing on its first tick
  assign st_eff = (vstate_r == VS_READY) ? VS_PLAYING : vstate_r;

  // Interpolation terms: b - a, then a + floor(diff * frac / 65536) centered on zero
  assign diff   = {1'b0, rd_data_r} - {1'b0, a_r};
  assign interp = {2'b00, a_r} - 10'd128 + {prod_r[24], prod_r[24:16]};

  assign mul_p = mul_a * mul_b;

  // Sequencer and next-state logic
  always_comb begin
    seq_nxt         = seq_r;
    phase_step_nxt  = phase_step_r;
    max_active_nxt  = max_active_r;
    max_stalled_nxt = max_stalled_r;
    read_phase_nxt  = read_phase_r;
    produced_nxt    = produced_r;
    final_nxt       = final_r;
    vstate_nxt      = vstate_r;
    cancel_nxt      = cancel_r;
    gain_nxt        = gain_r;
    active_nxt      = active_r;
    stalled_nxt     = stalled_r;
    seen_state_nxt  = seen_state_r;
    seen_phase_nxt  = seen_phase_r;
    seen_prod_nxt   = seen_prod_r;
    clr_idx_nxt     = clr_idx_r;
    nxt_addr_nxt    = nxt_addr_r;
    a_nxt           = a_r;
    prod_nxt        = prod_r;
    res_audio_nxt   = res_audio_r;
    res_acc_nxt     = res_acc_r;
    cmd_nxt         = cmd_r;
    out_valid_nxt   = out_valid_r;
    out_audio_nxt   = out_audio_r;
    out_acc_nxt     = out_acc_r;
    out_phase_nxt   = out_phase_r;
    out_cancel_nxt  = out_cancel_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_idx_r;
    mem_wdata       = SILENCE;
    rd_addr         = nxt_addr_r;
    mul_a           = '0;
    mul_b           = '0;

    // Register writes
    if (cfg_we) begin
      case (cfg_addr)
        CFG_PHASE_STEP:  phase_step_nxt  = cfg_wdata[16:0];
        CFG_MAX_ACTIVE:  max_active_nxt  = cfg_wdata;
        CFG_MAX_STALLED: max_stalled_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // Result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (seq_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_tuser;
          res_audio_nxt = '0;
          res_acc_nxt   = 1'b0;
          seq_nxt       = S_DONE;
          case (in_tuser)
            CMD_REQUEST: begin
              if (vstate_r == VS_IDLE && in_en) begin
                gain_nxt       = in_lvl;
                produced_nxt   = '0;
                final_nxt      = '0;
                active_nxt     = '0;
                stalled_nxt    = '0;
                seen_prod_nxt  = '0;
                seen_phase_nxt = '0;
                seen_state_nxt = VS_REQUESTED;
                cancel_nxt     = 1'b0;
                read_phase_nxt = '0;
                vstate_nxt     = VS_REQUESTED;
                res_acc_nxt    = 1'b1;
              end
            end
            CMD_BEGIN: begin
              if (vstate_r == VS_REQUESTED) begin
                vstate_nxt  = VS_RENDERING;
                clr_idx_nxt = '0;
                seq_nxt     = S_CLEAR;
              end
            end
            CMD_WRITE: begin
              if (vstate_r == VS_RENDERING && !cancel_r && in_pos < {7'b0, wr_limit}) begin
                mem_we      = 1'b1;
                mem_waddr   = in_pos[RING_AW-1:0];
                mem_wdata   = in_smp;
                res_acc_nxt = 1'b1;
                if (pos_inc > {1'b0, produced_r}) begin
                  produced_nxt = pos_inc[23:0];
                end
              end
            end
            CMD_END: begin
              if (vstate_r == VS_RENDERING) begin
                final_nxt  = cancel_r ? 24'd0 : in_cnt;
                vstate_nxt = (!cancel_r && in_cnt != 24'd0) ? VS_READY : VS_IDLE;
              end
            end
            CMD_TICK: begin
              if (vstate_r != VS_IDLE) begin
                active_nxt     = sat_inc24(active_r);
                stalled_nxt    = voice_moved ? 24'd0 : sat_inc24(stalled_r);
                seen_state_nxt = vstate_r;
                seen_phase_nxt = read_phase_r;
                seen_prod_nxt  = produced_r;
                seq_nxt        = S_WD;
              end else begin
                seq_nxt = S_CHK;
              end
            end
            default: ;
          endcase
        end
      end

      // Fill the ring with silence, one entry a cycle
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          seq_nxt = S_DONE;
        end
      end

      // Watchdog limits
      S_WD: begin
        if (active_r > max_active_r || stalled_r > max_stalled_r) begin
          cancel_nxt = 1'b1;
          if (vstate_r != VS_RENDERING && vstate_r != VS_REQUESTED) begin
            vstate_nxt = VS_IDLE;
          end
          seq_nxt = S_DONE;
        end else begin
          seq_nxt = S_CHK;
        end
      end

      // Decide whether this tick plays; read sample a
      S_CHK: begin
        rd_addr = rp_idx[RING_AW-1:0];
        seq_nxt = S_DONE;
        if (!(vstate_r == VS_RENDERING && produced_r < 24'(PREFILL_SAMPLES))) begin
          vstate_nxt = st_eff;
          if (st_eff == VS_RENDERING) begin
            if ({7'b0, idx_inc} < produced_r) begin
              nxt_addr_nxt = idx_inc[RING_AW-1:0];
              seq_nxt      = S_RDA;
            end
          end else if (st_eff == VS_PLAYING) begin
            if ({8'b0, rp_idx} >= final_r) begin
              vstate_nxt = VS_IDLE;
            end else begin
              // last source sample pairs with itself
              nxt_addr_nxt = ({7'b0, idx_inc} >= final_r) ? rp_idx[RING_AW-1:0]
                                                           : idx_inc[RING_AW-1:0];
              seq_nxt      = S_RDA;
            end
          end
        end
      end

      // Capture a, read b
      S_RDA: begin
        a_nxt   = rd_data_r;
        seq_nxt = S_RDB;
      end

      // (b - a) * fraction
      S_RDB: begin
        mul_a    = {{8{diff[8]}}, diff};
        mul_b    = {1'b0, read_phase_r[15:0]};
        prod_nxt = mul_p[24:0];
        seq_nxt  = S_GAIN;
      end

      // interpolated sample * gain
      S_GAIN: begin
        mul_a    = {{7{interp[9]}}, interp};
        mul_b    = {9'b0, gain_r};
        prod_nxt = mul_p[24:0];
        seq_nxt  = S_FIN;
      end

      // Double, wrap to 16 bits, advance phase
      S_FIN: begin
        res_audio_nxt  = {prod_r[14:0], 1'b0};
        read_phase_nxt = read_phase_r + {15'b0, phase_step_r};
        seq_nxt        = S_DONE;
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_audio_nxt  = res_audio_r;
          out_acc_nxt    = res_acc_r;
          out_phase_nxt  = vstate_r;
          out_cancel_nxt = cancel_r;
          seq_nxt        = S_IDLE;
        end
      end

      default: seq_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    clr_idx_r    <= clr_idx_nxt;
    nxt_addr_r   <= nxt_addr_nxt;
    a_r          <= a_nxt;
    prod_r       <= prod_nxt;
    res_audio_r  <= res_audio_nxt;
    res_acc_r    <= res_acc_nxt;
    cmd_r        <= cmd_nxt;
    out_audio_r  <= out_audio_nxt;
    out_acc_r    <= out_acc_nxt;
    out_phase_r  <= out_phase_nxt;
    out_cancel_r <= out_cancel_nxt;
    if (!rst_n) begin
      seq_r         <= S_IDLE;
      phase_step_r  <= PHASE_STEP_RST;
      max_active_r  <= MAX_ACTIVE_RST;
      max_stalled_r <= MAX_STALLED_RST;
      read_phase_r  <= '0;
      produced_r    <= '0;
      final_r       <= '0;
      vstate_r      <= VS_IDLE;
      cancel_r      <= 1'b0;
      gain_r        <= '0;
      active_r      <= '0;
      stalled_r     <= '0;
      seen_state_r  <= VS_REQUESTED;
      seen_phase_r  <= '0;
      seen_prod_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      seq_r         <= seq_nxt;
      phase_step_r  <= phase_step_nxt;
      max_active_r  <= max_active_nxt;
      max_stalled_r <= max_stalled_nxt;
      read_phase_r  <= read_phase_nxt;
      produced_r    <= produced_nxt;
      final_r       <= final_nxt;
      vstate_r      <= vstate_nxt;
      cancel_r      <= cancel_nxt;
      gain_r        <= gain_nxt;
      active_r      <= active_nxt;
      stalled_r     <= stalled_nxt;
      seen_state_r  <= seen_state_nxt;
      seen_phase_r  <= seen_phase_nxt;
      seen_prod_r   <= seen_prod_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // Checks
  `RBLR_AST_IMP(a_audio_needs_voice, out_valid_r && (out_audio_r != 16'd0), (out_phase_r == VS_PLAYING) || (out_phase_r == VS_RENDERING), "audio on a voice that is not playing")
  `RBLR_AST_IMP(a_accept_cmd, (seq_r == S_DONE) && res_acc_r, (cmd_r == CMD_REQUEST) || (cmd_r == CMD_WRITE), "accepted set for a command that cannot be accepted")
  `RBLR_AST_NXT(a_clear_to_render, (seq_r == S_CLEAR) && (&clr_idx_r), (vstate_r == VS_RENDERING) && (seq_r == S_DONE), "ring clear did not end in rendering")
  `RBLR_AST_IMP(a_phase_moves, !$stable(read_phase_r), $past(seq_r == S_FIN) || $past(in_fire && (in_tuser == CMD_REQUEST)) || !$past(rst_n), "read phase moved outside a tick or request")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rblr_pkg::*;

  // Command codes the block does not define; it must answer them with status only
  localparam cmd_t CMD_RSVD_FIRST = 3'd5;
  localparam cmd_t CMD_RSVD_LAST  = 3'd7;
  localparam int   CLK_HALF       = 5;
  localparam int   MAX_PRINTS     = 30;
  localparam int   PLAY_GUARD     = 600;

  // Input item fields, same order as in_tdata from the top bit down
  typedef struct packed {
    logic        en;
    logic [7:0]  lvl;
    logic [23:0] cnt;
    logic [7:0]  smp;
    logic [23:0] pos;
  } voice_cmd_t;

  // Result item fields, same order as out_tdata from bit 20 down
  typedef struct packed {
    logic        cancelled;
    vstate_t     phase;
    logic        accepted;
    logic [15:0] audio;
  } voice_status_t;

  // Voice predictor and status checker
  class voice_scoreboard;
    bit [16:0]     step;
    bit [23:0]     max_active;
    bit [23:0]     max_stalled;
    bit [7:0]      ring [RING_DEPTH];
    bit [31:0]     rphase;
    bit [23:0]     produced;
    bit [23:0]     final_cnt;
    vstate_t       vstate;
    bit            cancelled;
    bit [7:0]      level;
    bit [23:0]     active_ticks;
    bit [23:0]     stalled_ticks;
    vstate_t       seen_state;
    bit [31:0]     seen_phase;
    bit [23:0]     seen_produced;
    voice_status_t status_q[$];
    int            errors, checked, commands, voices, cancels, audible;

    function new();
      foreach (ring[i]) ring[i] = SILENCE;
      step          = PHASE_STEP_RST;
      max_active    = MAX_ACTIVE_RST;
      max_stalled   = MAX_STALLED_RST;
      rphase        = '0;
      produced      = '0;
      final_cnt     = '0;
      vstate        = VS_IDLE;
      cancelled     = 1'b0;
      level         = '0;
      active_ticks  = '0;
      stalled_ticks = '0;
      seen_state    = VS_REQUESTED;
      seen_phase    = '0;
      seen_produced = '0;
    endfunction

    function bit [23:0] bump(bit [23:0] v);
      return (v == 24'hFF_FFFF) ? v : v + 24'd1;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    task set_reg(cfg_idx_t idx, logic [23:0] v);
      case (idx)
        CFG_PHASE_STEP:  step = v[16:0];
        CFG_MAX_ACTIVE:  max_active = v;
        CFG_MAX_STALLED: max_stalled = v;
        default: ;
      endcase
    endtask

    // One output tick: watchdog, then interpolation of two ring samples
    function bit [15:0] play_tick();
      bit [31:0] idx, nxt;
      int        a, b, prod, interp, scaled;
      vstate_t   st;
      st = vstate;
      if (st != VS_IDLE) begin
        active_ticks = bump(active_ticks);
        if (st != seen_state || rphase != seen_phase || produced != seen_produced)
          stalled_ticks = '0;
        else
          stalled_ticks = bump(stalled_ticks);
        seen_state    = st;
        seen_phase    = rphase;
        seen_produced = produced;
        if (active_ticks > max_active || stalled_ticks > max_stalled) begin
          cancelled = 1'b1;
          cancels++;
          // producer still owns the voice until render end
          if (st != VS_RENDERING && st != VS_REQUESTED) vstate = VS_IDLE;
          return '0;
        end
      end
      if (vstate == VS_RENDERING && produced < PREFILL_SAMPLES) return '0;
      if (vstate == VS_READY) vstate = VS_PLAYING;
      if (vstate != VS_PLAYING && vstate != VS_RENDERING) return '0;
      idx = rphase >> 16;
      if (vstate == VS_RENDERING && idx + 32'd1 >= produced) return '0;
      if (vstate == VS_PLAYING && idx >= final_cnt) begin
        vstate = VS_IDLE;
        return '0;
      end
      nxt = idx + 32'd1;
      // hold the last sample at the tail of the voice
      if (vstate == VS_PLAYING && nxt >= final_cnt) nxt = idx;
      a      = int'(ring[idx % RING_DEPTH]) - int'(SILENCE);
      b      = int'(ring[nxt % RING_DEPTH]) - int'(SILENCE);
      prod   = (b - a) * int'(rphase[15:0]);
      interp = a + (prod >>> 16);
      rphase = rphase + step;
      scaled = interp * int'(level) * 2;
      return scaled[15:0];
    endfunction

    // Accepted input item: advance the voice and queue its status
    task note_command(cmd_t c, voice_cmd_t f);
      voice_status_t s;
      bit [31:0]     limit;
      s = '0;
      commands++;
      case (c)
        CMD_REQUEST: begin
          if (vstate == VS_IDLE && f.en) begin
            level         = f.lvl;
            produced      = '0;
            final_cnt     = '0;
            active_ticks  = '0;
            stalled_ticks = '0;
            seen_produced = '0;
            seen_phase    = '0;
            seen_state    = VS_REQUESTED;
            cancelled     = 1'b0;
            rphase        = '0;
            vstate        = VS_REQUESTED;
            s.accepted    = 1'b1;
            voices++;
          end
        end
        CMD_BEGIN: begin
          if (vstate == VS_REQUESTED) begin
            vstate = VS_RENDERING;
            foreach (ring[i]) ring[i] = SILENCE;
          end
        end
        CMD_WRITE: begin
          limit = (rphase >> 16) + RING_DEPTH - WRITE_GUARD;
          if (vstate == VS_RENDERING && !cancelled && f.pos < limit) begin
            ring[f.pos % RING_DEPTH] = f.smp;
            if (f.pos + 24'd1 > produced) produced = f.pos + 24'd1;
            s.accepted = 1'b1;
          end
        end
        CMD_END: begin
          if (vstate == VS_RENDERING) begin
            final_cnt = cancelled ? 24'd0 : f.cnt;
            vstate    = (final_cnt != 0) ? VS_READY : VS_IDLE;
          end
        end
        CMD_TICK: s.audio = play_tick();
        default: ;
      endcase
      s.phase     = vstate;
      s.cancelled = cancelled;
      if (s.audio != 0) audible++;
      status_q.push_back(s);
    endtask

    task report(string what, logic [23:0] got, logic [23:0] want);
      if (errors < MAX_PRINTS)
        $display("MISMATCH %s at status item %0d: got 0x%0h, expected 0x%0h",
                 what, checked, got, want);
      errors++;
    endtask

    // Accepted result item against the oldest queued status
    task check_status(logic [23:0] raw);
      voice_status_t got, want;
      got = voice_status_t'(raw[20:0]);
      checked++;
      if (status_q.size() == 0) begin
        report("unexpected status item", raw, '0);
        return;
      end
      want = status_q.pop_front();
      if (got.audio != want.audio) report("audio_out", got.audio, want.audio);
      if (got.accepted != want.accepted) report("accepted", got.accepted, want.accepted);
      if (got.phase != want.phase) report("voice_phase", got.phase, want.phase);
      if (got.cancelled != want.cancelled)
        report("was_cancelled", got.cancelled, want.cancelled);
    endtask

    task flush_leftover();
      while (status_q.size() != 0) report("missing status item", '0, status_q.pop_front());
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  cmd_t        in_tuser = CMD_REQUEST;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_addr = CFG_PHASE_STEP;
  logic [23:0] cfg_wdata = '0;

  int snd_idle = 0;
  int rcv_idle = 0;
  int sent = 0;
  voice_scoreboard sb;

  ring_buffer_linear_resampler_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Result side back-pressure
  always @(negedge clk) out_tready = ($urandom_range(99) >= rcv_idle);

  // Sample handshakes and register writes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_command(in_tuser, voice_cmd_t'(in_tdata[64:0]));
      if (out_tvalid && out_tready) sb.check_status(out_tdata);
    end
  end

  function automatic voice_cmd_t junk();
    voice_cmd_t f;
    f.pos = 24'($urandom);
    f.smp = 8'($urandom);
    f.cnt = 24'($urandom);
    f.lvl = 8'($urandom);
    f.en  = 1'($urandom);
    return f;
  endfunction

  // Present one item after a random gap; returns at the falling edge after acceptance
  task automatic send(cmd_t c, voice_cmd_t f);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = c;
    in_tdata  = {7'd0, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (c <= CMD_TICK) sent++;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Walk any open voice back to idle
  task automatic settle();
    voice_cmd_t f;
    int         guard;
    guard = 0;
    while (sb.vstate != VS_IDLE && guard < PLAY_GUARD) begin
      f = junk();
      case (sb.vstate)
        VS_REQUESTED: send(CMD_BEGIN, f);
        VS_RENDERING: begin
          f.cnt = '0;
          send(CMD_END, f);
        end
        default: send(CMD_TICK, f);
      endcase
      guard++;
    end
  endtask

  // Noise while idle: any code, any field values
  task automatic stray_items();
    repeat ($urandom_range(1, 3)) begin
      if (sb.vstate != VS_IDLE) break;
      send(cmd_t'($urandom_range(CMD_RSVD_LAST)), junk());
    end
  endtask

  // One voice: request, render with interleaved ticks, close, play out
  task automatic play_voice();
    voice_cmd_t f;
    int         n, i, guard;
    settle();
    f = junk();
    f.en = ($urandom_range(9) != 0);
    send(CMD_REQUEST, f);
    if (sb.vstate != VS_REQUESTED) begin
      send(CMD_TICK, junk());
      send(CMD_WRITE, junk());
      return;
    end
    repeat ($urandom_range(2)) send(CMD_TICK, junk());
    send(CMD_BEGIN, junk());
    n = ($urandom_range(7) == 0) ? $urandom_range(66, 90) : $urandom_range(2, 20);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3) send(CMD_TICK, junk());
      f = junk();
      case ($urandom_range(19))
        // around the write guard: one below, at, and one past the limit
        0: f.pos = 24'((sb.rphase >> 16) + RING_DEPTH - WRITE_GUARD - 1 + $urandom_range(2));
        1: ;
        2: f.pos = (i > 0) ? 24'(i - 1) : 24'(i);
        default: f.pos = 24'(i);
      endcase
      send(CMD_WRITE, f);
    end
    f = junk();
    if (!sb.cancelled) begin
      case ($urandom_range(9))
        0: f.cnt = '0;
        1: f.cnt = 24'(n + $urandom_range(1, 8));
        default: f.cnt = 24'(n);
      endcase
    end
    send(CMD_END, f);
    guard = 0;
    while (sb.vstate != VS_IDLE && guard < PLAY_GUARD) begin
      send(CMD_TICK, junk());
      guard++;
    end
  endtask

  task automatic run_segment(int snd, int rcv, logic [16:0] step, logic [23:0] act,
                             logic [23:0] stl, int target);
    int start;
    in_tvalid = 1'b0;
    drain();
    cfg_we    = 1'b1;
    cfg_addr  = CFG_PHASE_STEP;
    cfg_wdata = 24'(step);
    @(negedge clk);
    cfg_addr  = CFG_MAX_ACTIVE;
    cfg_wdata = act;
    @(negedge clk);
    cfg_addr  = CFG_MAX_STALLED;
    cfg_wdata = stl;
    @(negedge clk);
    cfg_we    = 1'b0;
    snd_idle  = snd;
    rcv_idle  = rcv;
    start     = sent;
    while (sent - start < target) begin
      if ($urandom_range(7) == 0) stray_items();
      else play_voice();
    end
  endtask

  // Directed opening: every command in every relevant state, field extremes
  task automatic directed_items();
    voice_cmd_t f;
    int         guard;
    send(CMD_TICK, '0);
    send(CMD_RSVD_FIRST, '1);
    send(CMD_RSVD_LAST, junk());
    send(CMD_BEGIN, junk());
    send(CMD_END, '1);
    send(CMD_WRITE, '0);
    f = '1;
    f.en = 1'b0;
    send(CMD_REQUEST, f);
    send(CMD_REQUEST, '1);
    f = '0;
    f.en = 1'b1;
    send(CMD_REQUEST, f);
    send(CMD_WRITE, '0);
    send(CMD_END, '1);
    send(CMD_TICK, '0);
    send(CMD_BEGIN, '0);
    send(CMD_TICK, '0);
    // steepest rising edge and a steep falling edge between neighbors
    f = '0;
    send(CMD_WRITE, f);
    f.pos = 24'd1;
    f.smp = 8'hFF;
    send(CMD_WRITE, f);
    f.pos = 24'd2;
    f.smp = 8'd1;
    send(CMD_WRITE, f);
    f.pos = '1;
    send(CMD_WRITE, f);
    f.pos = 24'(RING_DEPTH - WRITE_GUARD);
    send(CMD_WRITE, f);
    f.pos = 24'(RING_DEPTH - WRITE_GUARD - 1);
    f.smp = 8'hFF;
    send(CMD_WRITE, f);
    send(CMD_TICK, '0);
    f = '0;
    f.cnt = 24'd3;
    send(CMD_END, f);
    guard = 0;
    while (sb.vstate != VS_IDLE && guard < PLAY_GUARD) begin
      send(CMD_TICK, junk());
      guard++;
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    snd_idle = 38;
    rcv_idle = 59;
    directed_items();
    // a segment overshoots its target by the rest of its last voice
    run_segment(38, 59, PHASE_STEP_RST, MAX_ACTIVE_RST, MAX_STALLED_RST, 40);
    run_segment(38, 59, 17'h1_0000, 24'hFF_FFFF, 24'hFF_FFFF, 40);
    run_segment(59, 38, 17'd1, 24'd40, 24'd1, 45);
    run_segment(59, 38, 17'($urandom_range(20000, 65536)), 24'd1, 24'hFF_FFFF, 40);
    run_segment(0, 0, 17'd49152, 24'($urandom_range(50, 300)),
                24'($urandom_range(2, 12)), 45);
    run_segment(0, 0, PHASE_STEP_RST, MAX_ACTIVE_RST, MAX_STALLED_RST, 35);
    in_tvalid = 1'b0;
    drain();
    sb.flush_leftover();
    $display("Sent %0d commands over %0d voices and six register settings;",
             sb.commands, sb.voices);
    $display("checked %0d status items, %0d audible samples, %0d watchdog cancels",
             sb.checked, sb.audible, sb.cancels);
    if (sb.errors == 0) begin
      $display("** ring_buffer_linear_resampler_unit: PASSED **");
    end else begin
      $display("** ring_buffer_linear_resampler_unit: FAILED **");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10ms;
    $display("Timeout with %0d status items outstanding", sb.pending());
    $display("** ring_buffer_linear_resampler_unit: FAILED **");
    $finish;
  end

endmodule
